// ----- sv/sbst_pkg.sv -----
package sbst_pkg;

    localparam int MAX_NODES   = 64;
    localparam int WEIGHT_BITS = 24;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS    = $clog2(MAX_NODES + 1);
    localparam int ADDR_BITS   = 2 * NODE_BITS;
    localparam int STORE_DEPTH = MAX_NODES * MAX_NODES;
    localparam int KEY_BITS    = WEIGHT_BITS + 1;
    localparam int SUM_BITS    = WEIGHT_BITS + NODE_BITS + 1;
    localparam int COST_BITS   = 31;
    localparam int CFG_BITS    = 7;

    localparam logic [KEY_BITS-1:0] KEY_INFINITY = KEY_BITS'(1) << WEIGHT_BITS;
    localparam logic [KEY_BITS-1:0] KEY_START    = KEY_INFINITY + KEY_BITS'(1);

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] edge_cost;
        logic                   last_weight;
    } edge_item_t;

    typedef struct packed {
        logic [COST_BITS-1:0] total_cost;
        logic                 no_alternative;
    } result_item_t;

    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   addr;
        logic [WEIGHT_BITS-1:0] data;
    } load_wr_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_MARK,
        S_PATH_RD,
        S_PATH_WA,
        S_PATH_WB,
        S_UPD_RD,
        S_UPD_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } core_state_t;

    // Load position of the upper-triangle edge between nodes a and b.
    function automatic logic [ADDR_BITS-1:0] tri_pos(
        input logic [NODE_BITS-1:0] a,
        input logic [NODE_BITS-1:0] b,
        input logic [CNT_BITS-1:0]  n
    );
        logic [ADDR_BITS-1:0] j;
        logic [ADDR_BITS-1:0] k;
        logic [ADDR_BITS-1:0] tri_base;
        j = (a < b) ? ADDR_BITS'(a) : ADDR_BITS'(b);
        k = (a < b) ? ADDR_BITS'(b) : ADDR_BITS'(a);
        tri_base = ADDR_BITS'((j * (j + ADDR_BITS'(1))) >> 1);
        return ADDR_BITS'(j * ADDR_BITS'(n)) - tri_base + k - j - ADDR_BITS'(1);
    endfunction

endpackage

// ----- sv/second_best_spanning_tree_cost.sv -----
// Channel   Direction  Signals                                    Moves
// edge      in         edge_valid, edge_ready, edge_data          one weight per transfer
// result    out        result_valid, result_ready, result_data    one cost per graph
// cfg       in         cfg_we, cfg_wdata                          node count, no wait
//
// Loading stores each accepted weight while positions remain.
// After the last weight, the sequencer runs, for each tree step, the Prim search
// (read and compare per open node), a marking step, the path-max update (read and two
// writes per finished node other than the one just marked) and the key update (read and
// compare per open node), then the pair scan (read and compare per pair); the single read port of each store sets this.
// edge_ready is low while the sequencer runs or holds a result the output register
// cannot yet take. Reset needs no clearing pass; the result register holds until its transfer.
module second_best_spanning_tree_cost (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          edge_valid,
    output logic                          edge_ready,
    input  sbst_pkg::edge_item_t          edge_data,
    output logic                          result_valid,
    input  logic                          result_ready,
    output sbst_pkg::result_item_t        result_data,
    input  logic                          cfg_we,
    input  logic [sbst_pkg::CFG_BITS-1:0] cfg_wdata
);
    import sbst_pkg::*;

    logic [CFG_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  n_eff;
    logic [ADDR_BITS-1:0] edge_total;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;
    logic                 accept;
    logic                 start;
    logic                 ack;
    logic                 res_valid_reg, res_valid_next;
    result_item_t         res_reg;
    result_item_t         core_result;
    core_stat_t           stat;
    load_wr_t             load_wr;

    // Clamp the node count into its legal range.
    always_comb
    begin
        if (32'(count_reg) < 32'(2))
        begin
            n_eff = CNT_BITS'(2);
        end
        else if (32'(count_reg) > 32'(MAX_NODES))
        begin
            n_eff = CNT_BITS'(MAX_NODES);
        end
        else
        begin
            n_eff = CNT_BITS'(count_reg);
        end
    end

    assign edge_total =
        ADDR_BITS'((ADDR_BITS'(n_eff) * (ADDR_BITS'(n_eff) - ADDR_BITS'(1))) >> 1);

    // Load path: store the weight while positions remain.
    assign edge_ready   = stat.idle;
    assign accept       = edge_valid && edge_ready;
    assign start        = accept && edge_data.last_weight;
    assign load_wr.we   = accept && (pos_reg < edge_total);
    assign load_wr.addr = pos_reg;
    assign load_wr.data = edge_data.edge_cost;

    always_comb
    begin
        pos_next = pos_reg;
        if (load_wr.we)
        begin
            pos_next = pos_reg + ADDR_BITS'(1);
        end
        if (start)
        begin
            pos_next = '0;
        end
    end

    // Output register takes the result once it is empty.
    assign ack = stat.done && !res_valid_reg;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result_valid && result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (ack)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CFG_BITS'(2);
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            res_reg <= core_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

    sbst_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .n       (n_eff),
        .start   (start),
        .ack     (ack),
        .load_wr (load_wr),
        .stat    (stat),
        .result  (core_result)
    );

endmodule

// ----- sv/sbst_core.sv -----
module sbst_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sbst_pkg::CNT_BITS-1:0] n,
    input  logic                          start,
    input  logic                          ack,
    input  sbst_pkg::load_wr_t            load_wr,
    output sbst_pkg::core_stat_t          stat,
    output sbst_pkg::result_item_t        result
);
    import sbst_pkg::*;

    // Weight store and path-maximum store; path word is {tree flag, max}.
    logic [WEIGHT_BITS-1:0] wmem [STORE_DEPTH];
    logic [KEY_BITS-1:0]    pmem [STORE_DEPTH];
    logic [WEIGHT_BITS-1:0] w_rdata_reg;
    logic [KEY_BITS-1:0]    pm_rdata_reg;
    logic [ADDR_BITS-1:0]   w_raddr;
    logic [ADDR_BITS-1:0]   pm_raddr;
    logic                   pm_we;
    logic [ADDR_BITS-1:0]   pm_waddr;
    logic [KEY_BITS-1:0]    pm_wdata;

    // Prim working values; key and parent are registered reads addressed by the node counter.
    logic [KEY_BITS-1:0]  kmem   [MAX_NODES];
    logic [NODE_BITS-1:0] parmem [MAX_NODES];
    logic [KEY_BITS-1:0]  k_rdata_reg;
    logic [NODE_BITS-1:0] par_rdata_reg;
    logic                 key_ok_reg;
    logic [KEY_BITS-1:0]  key_cur;
    logic [MAX_NODES-1:0] key_set_reg;
    logic [MAX_NODES-1:0] done_reg;
    logic                 key_we;
    logic                 mark_we;

    core_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]  v_reg, v_next;
    logic [CNT_BITS-1:0]  j_reg, j_next;
    logic [NODE_BITS-1:0] u_reg, u_next;
    logic [NODE_BITS-1:0] p_reg, p_next;
    logic [KEY_BITS-1:0]  least_reg, least_next;
    logic [KEY_BITS-1:0]  hold_reg, hold_next;
    logic [SUM_BITS-1:0]  cost_reg, cost_next;
    logic [WEIGHT_BITS-1:0] best_reg, best_next;
    logic                 found_reg, found_next;

    logic [NODE_BITS-1:0] vi;
    logic [NODE_BITS-1:0] ji;
    logic                 v_last;
    logic                 step_last;
    logic                 path_hit;
    logic [WEIGHT_BITS-1:0] path_max;
    logic [WEIGHT_BITS-1:0] diff;

    assign vi        = v_reg[NODE_BITS-1:0];
    assign ji        = j_reg[NODE_BITS-1:0];
    assign v_last    = (v_reg == n - CNT_BITS'(1));
    assign step_last = (step_reg == n - CNT_BITS'(1));
    assign path_hit  = done_reg[vi] && (vi != u_reg);

    // A key never set in this run counts as infinite.
    assign key_cur = key_ok_reg ? k_rdata_reg : KEY_INFINITY;

    // Shared compare unit operands.
    assign path_max = (least_reg[WEIGHT_BITS-1:0] > pm_rdata_reg[WEIGHT_BITS-1:0])
                    ? least_reg[WEIGHT_BITS-1:0] : pm_rdata_reg[WEIGHT_BITS-1:0];
    assign diff = (w_rdata_reg >= pm_rdata_reg[WEIGHT_BITS-1:0])
                ? w_rdata_reg - pm_rdata_reg[WEIGHT_BITS-1:0] : '0;

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (load_wr.we)
        begin
            wmem[load_wr.addr] <= load_wr.data;
        end
        w_rdata_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pmem[pm_waddr] <= pm_wdata;
        end
        pm_rdata_reg <= pmem[pm_raddr];
    end

    // Key and parent stores, addressed by the node counter.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            kmem[0] <= '0;
        end
        else if (key_we)
        begin
            kmem[vi]   <= KEY_BITS'(w_rdata_reg);
            parmem[vi] <= u_reg;
        end
        k_rdata_reg   <= kmem[vi];
        par_rdata_reg <= parmem[vi];
        key_ok_reg    <= key_set_reg[vi];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (start) state_next = S_INIT;
            S_INIT:     state_next = S_SEARCH_RD;
            S_SEARCH_RD:
            begin
                if (!done_reg[vi]) state_next = S_SEARCH_CMP;
                else if (v_last) state_next = S_MARK;
            end
            S_SEARCH_CMP: state_next = v_last ? S_MARK : S_SEARCH_RD;
            S_MARK:     state_next = (step_reg != '0) ? S_PATH_RD : S_UPD_RD;
            S_PATH_RD:
            begin
                if (path_hit) state_next = S_PATH_WA;
                else if (v_last) state_next = S_UPD_RD;
            end
            S_PATH_WA:  state_next = S_PATH_WB;
            S_PATH_WB:  state_next = v_last ? S_UPD_RD : S_PATH_RD;
            S_UPD_RD:
            begin
                if (!done_reg[vi]) state_next = S_UPD_CMP;
                else if (v_last) state_next = step_last ? S_SCAN_RD : S_SEARCH_RD;
            end
            S_UPD_CMP:
            begin
                if (v_last) state_next = step_last ? S_SCAN_RD : S_SEARCH_RD;
                else state_next = S_UPD_RD;
            end
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (v_last && (j_reg == n - CNT_BITS'(2))) state_next = S_DONE;
                else state_next = S_SCAN_RD;
            end
            S_DONE:     if (ack) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        step_next  = step_reg;
        v_next     = v_reg;
        j_next     = j_reg;
        u_next     = u_reg;
        p_next     = p_reg;
        least_next = least_reg;
        hold_next  = hold_reg;
        cost_next  = cost_reg;
        best_next  = best_reg;
        found_next = found_reg;
        key_we     = 1'b0;
        mark_we    = 1'b0;
        pm_we      = 1'b0;
        pm_waddr   = {u_reg, u_reg};
        pm_wdata   = '0;
        pm_raddr   = {vi, p_reg};
        w_raddr    = tri_pos(u_reg, vi, n);
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_INIT:
            begin
                step_next  = '0;
                v_next     = '0;
                least_next = KEY_START;
                cost_next  = '0;
                found_next = 1'b0;
                best_next  = '0;
            end
            S_SEARCH_RD:
            begin
                // Finished nodes are skipped without waiting for their key.
                if (done_reg[vi])
                begin
                    v_next = v_last ? '0 : v_reg + CNT_BITS'(1);
                end
            end
            S_SEARCH_CMP:
            begin
                if (key_cur < least_reg)
                begin
                    least_next = key_cur;
                    u_next     = vi;
                    p_next     = key_ok_reg ? par_rdata_reg : '0;
                end
                v_next = v_last ? '0 : v_reg + CNT_BITS'(1);
            end
            S_MARK:
            begin
                mark_we  = 1'b1;
                pm_we    = 1'b1;
                pm_waddr = {u_reg, u_reg};
                pm_wdata = '0;
                if (step_reg != '0)
                begin
                    cost_next = cost_reg + SUM_BITS'(least_reg[WEIGHT_BITS-1:0]);
                end
            end
            S_PATH_RD:
            begin
                pm_raddr = {vi, p_reg};
                if (!path_hit)
                begin
                    v_next = v_last ? '0 : v_reg + CNT_BITS'(1);
                end
            end
            S_PATH_WA:
            begin
                hold_next = {(vi == p_reg), path_max};
                pm_we     = 1'b1;
                pm_waddr  = {vi, u_reg};
                pm_wdata  = {(vi == p_reg), path_max};
            end
            S_PATH_WB:
            begin
                pm_we    = 1'b1;
                pm_waddr = {u_reg, vi};
                pm_wdata = hold_reg;
                v_next   = v_last ? '0 : v_reg + CNT_BITS'(1);
            end
            S_UPD_RD:
            begin
                w_raddr = tri_pos(u_reg, vi, n);
                if (done_reg[vi])
                begin
                    v_next = v_last ? '0 : v_reg + CNT_BITS'(1);
                    if (v_last)
                    begin
                        step_next  = step_reg + CNT_BITS'(1);
                        least_next = KEY_START;
                        j_next     = '0;
                        v_next     = step_last ? CNT_BITS'(1) : '0;
                    end
                end
            end
            S_UPD_CMP:
            begin
                key_we = (KEY_BITS'(w_rdata_reg) < key_cur);
                v_next = v_reg + CNT_BITS'(1);
                if (v_last)
                begin
                    step_next  = step_reg + CNT_BITS'(1);
                    least_next = KEY_START;
                    j_next     = '0;
                    v_next     = step_last ? CNT_BITS'(1) : '0;
                end
            end
            S_SCAN_RD:
            begin
                pm_raddr = {ji, vi};
                w_raddr  = tri_pos(ji, vi, n);
            end
            S_SCAN_CMP:
            begin
                // Non-tree pairs only; keep the least increase.
                if (!pm_rdata_reg[WEIGHT_BITS] && (!found_reg || (diff < best_reg)))
                begin
                    best_next  = diff;
                    found_next = 1'b1;
                end
                if (v_last)
                begin
                    j_next = j_reg + CNT_BITS'(1);
                    v_next = j_reg + CNT_BITS'(2);
                end
                else
                begin
                    v_next = v_reg + CNT_BITS'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= '0;
            key_set_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INIT)
            begin
                done_reg    <= '0;
                key_set_reg <= MAX_NODES'(1);
            end
            else
            begin
                if (mark_we)
                begin
                    done_reg[u_reg] <= 1'b1;
                end
                if (key_we)
                begin
                    key_set_reg[vi] <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        v_reg     <= v_next;
        j_reg     <= j_next;
        u_reg     <= u_next;
        p_reg     <= p_next;
        least_reg <= least_next;
        hold_reg  <= hold_next;
        cost_reg  <= cost_next;
        best_reg  <= best_next;
        found_reg <= found_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign result.total_cost =
        found_reg ? COST_BITS'(cost_reg + SUM_BITS'(best_reg)) : '0;
    assign result.no_alternative = !found_reg;

endmodule
